/* design/sbh_pkg.sv */
// Shared widths, configuration codes and status types for the string bucket hash.
package sbh_pkg;

  // Default accumulator width of the hash.
  localparam int HASH_WIDTH_DEFAULT = 64;

  // Fixed field widths.
  localparam int CHAR_W   = 8;
  localparam int BUCKET_W = 31;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'd1;

  // Fill status of the key queue, seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* design/sbh_front.sv */
// Front end: folds case, accumulates the hash per character and queues finished keys.
module sbh_front import sbh_pkg::*; #(
  parameter int HASH_WIDTH = HASH_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CHAR_W-1:0]            char_code,
  input  logic                         last_char,
  input  logic                         case_fold,
  input  logic [BUCKET_W-1:0]          bucket_count,
  input  q_status_t                    q_status,
  output logic                         q_push,
  output logic [BUCKET_W+HASH_WIDTH-1:0] q_data
);

  logic [HASH_WIDTH-1:0] hash;
  logic [HASH_WIDTH-1:0] hash_next;
  logic [CHAR_W-1:0]     folded;
  logic                  accept;

  // A final character needs a free queue slot; other characters always go in.
  assign in_stall = last_char && q_status.full;
  assign accept   = in_valid && !in_stall;

  // Lower ASCII upper-case letters when folding is on.
  always_comb begin
    folded = char_code;
    if (case_fold && (char_code >= 8'h41) && (char_code <= 8'h5A)) begin
      folded = char_code + 8'h20;
    end
  end

  // Multiply by 65599 as (h << 16) + (h << 6) - h, wrapping at the accumulator width.
  assign hash_next = (hash << 16) + (hash << 6) - hash
                     + {{(HASH_WIDTH-CHAR_W){1'b0}}, folded};

  // The finished hash travels with the bucket count of its final character.
  assign q_push = accept && last_char;
  assign q_data = {bucket_count, hash_next};

  // Accumulator update; cleared after each key.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (accept) begin
      if (last_char) begin
        hash <= '0;
      end else begin
        hash <= hash_next;
      end
    end
  end

endmodule

/* design/sbh_queue.sv */
// Two-entry queue of finished keys between the front and back ends.
module sbh_queue import sbh_pkg::*; #(
  parameter int DATA_W = BUCKET_W + HASH_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_status_t         status
);

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data     = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/sbh_back.sv */
// Back end: bit-serial restoring modulo of each queued hash and the result register.
module sbh_back import sbh_pkg::*; #(
  parameter int HASH_WIDTH = HASH_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  q_status_t                      q_status,
  input  logic [BUCKET_W+HASH_WIDTH-1:0] q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [BUCKET_W-1:0]            bucket_index
);

  localparam int CNT_W = $clog2(HASH_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      count;
  logic [HASH_WIDTH-1:0] dividend;
  logic [BUCKET_W-1:0]   divisor;
  logic [BUCKET_W-1:0]   rem;
  logic [BUCKET_W:0]     trial;
  logic [BUCKET_W-1:0]   rem_next;
  logic [BUCKET_W-1:0]   q_count;
  logic                  out_free;

  assign q_count  = q_data[BUCKET_W+HASH_WIDTH-1:HASH_WIDTH];
  assign q_pop    = (state == ST_IDLE) && !q_status.empty;
  assign out_free = !out_valid || !out_stall;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem, dividend[HASH_WIDTH-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = BUCKET_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[BUCKET_W-1:0];
    end
  end

  // Divider sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_RUN;
            count <= CNT_W'(HASH_WIDTH - 1);
          end
        end
        ST_RUN: begin
          count <= count - CNT_W'(1);
          if (count == '0) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Divider datapath; a zero bucket count divides by one.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dividend <= q_data[HASH_WIDTH-1:0];
      divisor  <= (q_count == '0) ? BUCKET_W'(1) : q_count;
      rem      <= '0;
    end else if (state == ST_RUN) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
    end
  end

  // Result register; loads once the previous transaction has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && out_free) begin
      bucket_index <= rem;
    end
  end

endmodule

/* design/string_bucket_hash.sv */
// Top level of the string bucket hash: configuration registers, front, queue and back end.
//
// Characters of a key name are taken one per cycle, and the multiply-by-65599 accumulator
// keeps up with that rate. Each final character pushes the key's hash into a two-entry queue;
// the back end reduces it modulo the bucket count with a restoring divider that handles one
// dividend bit per cycle and takes the next key once its result is loaded. While
// the queue is full the final character of the next key is held off; the characters before
// it still flow. A result waits in an output register until it is taken, and bucket_count is
// sampled when the final character of a key is accepted.
module string_bucket_hash import sbh_pkg::*; #(
  parameter int HASH_WIDTH = HASH_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic                  last_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BUCKET_W-1:0]   bucket_index
);

  localparam int Q_W = BUCKET_W + HASH_WIDTH;

  logic                case_fold;
  logic [BUCKET_W-1:0] bucket_count;
  q_status_t           q_status;
  logic                q_push;
  logic                q_pop;
  logic [Q_W-1:0]      q_push_data;
  logic [Q_W-1:0]      q_pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold    <= 1'b0;
      bucket_count <= BUCKET_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CASE_FOLD:    case_fold    <= cfg_data[0];
        CFG_BUCKET_COUNT: bucket_count <= cfg_data[BUCKET_W-1:0];
        default:          ;
      endcase
    end
  end

  sbh_front #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .last_char   (last_char),
    .case_fold   (case_fold),
    .bucket_count(bucket_count),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  sbh_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .status   (q_status)
  );

  sbh_back #(
    .HASH_WIDTH(HASH_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bucket_index(bucket_index)
  );

endmodule

/* verif/string_bucket_hash_tb.sv */
// Self-checking testbench for the string bucket hash: directed table, random keys, predictor.
module string_bucket_hash_tb;
  import sbh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HW           = HASH_WIDTH_DEFAULT;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = HW + 16;
  localparam int HOLD_LEN     = 300;
  localparam int SEG_CHARS    = 200;
  localparam int NUM_SEGS     = 6;
  localparam int LIMIT_CYCLES = 500000;
  localparam int MAX_REPORTS  = 20;

  // Kind of a row in the directed table.
  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [CHAR_W-1:0]     chr;
    logic                  lst;
    logic                  typed;
    logic [BUCKET_W-1:0]   exp_idx;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [CHAR_W-1:0]     char_code;
  logic                  last_char;
  logic                  out_valid;
  logic                  out_stall;
  logic [BUCKET_W-1:0]   bucket_index;

  // Predictor state: accumulator and a mirror of the registers.
  logic [HW-1:0]         hash_acc;
  logic                  fold_en;
  logic [BUCKET_W-1:0]   bucket_mod;
  logic [BUCKET_W-1:0]   bucket_expect[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_started;
  int hold_left;
  int cycle_count;
  int errors;
  int char_total;
  int key_total;
  int results_seen;
  int settings_total;

  row_t directed[$];
  row_t cur_row;
  int   seg;
  int   sent;
  int   key_len;
  int   pick;
  logic [CHAR_W-1:0] byte_val;
  logic [BUCKET_W-1:0] seg_bucket;

  string_bucket_hash dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bucket_index (bucket_index)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stall: a long hold when one is requested, random idling otherwise.
  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result transaction with the oldest expected bucket.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (bucket_expect.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual bucket_index=%0d",
                   $realtime, bucket_index);
      end else begin
        if (bucket_index !== bucket_expect[0]) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: bucket_index mismatch, expected %0d, actual %0d",
                     $realtime, bucket_expect[0], bucket_index);
        end
        void'(bucket_expect.pop_front());
      end
    end
  end

  function automatic row_t chr_row(input logic [CHAR_W-1:0] c, input logic lst);
    row_t r;
    r      = '0;
    r.kind = ROW_CHAR;
    r.chr  = c;
    r.lst  = lst;
    return r;
  endfunction

  function automatic row_t chk_row(input logic [CHAR_W-1:0] c, input logic [BUCKET_W-1:0] e);
    row_t r;
    r         = '0;
    r.kind    = ROW_CHAR;
    r.chr     = c;
    r.lst     = 1'b1;
    r.typed   = 1'b1;
    r.exp_idx = e;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] i, input logic [CFG_DATA_W-1:0] v);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = i;
    r.val  = v;
    return r;
  endfunction

  // Offer one character transaction, wait for it to be taken, then predict its effect.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst,
                           input logic typed, input logic [BUCKET_W-1:0] typed_idx);
    logic [CHAR_W-1:0]   folded;
    logic [BUCKET_W-1:0] modulus;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    folded = c;
    if (fold_en && c >= 8'h41 && c <= 8'h5A) folded = c + 8'h20;
    hash_acc = hash_acc * 64'd65599 + {{(HW-CHAR_W){1'b0}}, folded};
    char_total++;
    if (lst) begin
      modulus = (bucket_mod == '0) ? BUCKET_W'(1) : bucket_mod;
      bucket_expect.push_back(typed ? typed_idx : BUCKET_W'(hash_acc % modulus));
      hash_acc = '0;
      key_total++;
    end
  endtask

  // Register write once all results are in and the back end has had time to drain.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (bucket_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CASE_FOLD) fold_en = val[0];
    else if (idx == CFG_BUCKET_COUNT) bucket_mod = val[BUCKET_W-1:0];
    settings_total++;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    char_code     = '0;
    last_char     = 1'b0;
    out_stall     = 1'b0;
    hash_acc      = '0;
    fold_en       = 1'b0;
    bucket_mod    = BUCKET_W'(1);
    send_idle_pct = 7;
    recv_idle_pct = 56;
    hold_requests = 0;
    holds_started = 0;
    hold_left     = 0;
    cycle_count   = 0;
    errors        = 0;

    // Directed table: extremes, folding edges, zero byte, zero bucket count, mid-key change.
    directed.push_back(chk_row(8'h41, 31'd0));          // reset bucket count of one
    directed.push_back(cfg_row(CFG_BUCKET_COUNT, 31'h7FFF_FFFF));
    directed.push_back(chk_row(8'hFF, 31'd255));
    directed.push_back(chk_row(8'h00, 31'd0));          // zero byte as a one-byte key
    directed.push_back(chk_row(8'h41, 31'd65));         // no folding yet
    directed.push_back(cfg_row(CFG_CASE_FOLD, 31'd1));
    directed.push_back(chk_row(8'h41, 31'd97));
    directed.push_back(chk_row(8'h5A, 31'd122));
    directed.push_back(chk_row(8'h40, 31'd64));         // just below the letter range
    directed.push_back(chk_row(8'h5B, 31'd91));         // just above the letter range
    directed.push_back(chr_row(8'h48, 1'b0));
    directed.push_back(chr_row(8'h65, 1'b0));
    directed.push_back(chr_row(8'h6C, 1'b0));
    directed.push_back(chr_row(8'h6C, 1'b0));
    directed.push_back(chr_row(8'h4F, 1'b1));
    directed.push_back(chr_row(8'h00, 1'b0));           // zero byte does not end the key
    directed.push_back(chr_row(8'h01, 1'b1));
    directed.push_back(cfg_row(CFG_BUCKET_COUNT, 31'd0));
    directed.push_back(chr_row(8'h80, 1'b0));
    directed.push_back(chk_row(8'h7F, 31'd0));          // zero count acts as one
    directed.push_back(cfg_row(CFG_BUCKET_COUNT, 31'd1));
    directed.push_back(chk_row(8'h78, 31'd0));
    directed.push_back(cfg_row(CFG_BUCKET_COUNT, 31'd1000));
    directed.push_back(cfg_row(CFG_CASE_FOLD, 31'd0));
    directed.push_back(chr_row(8'h41, 1'b0));
    directed.push_back(cfg_row(CFG_CASE_FOLD, 31'd1)); // folding changes inside a key
    directed.push_back(chr_row(8'h42, 1'b1));
    directed.push_back(chr_row(8'hFF, 1'b0));           // long enough to wrap the accumulator
    directed.push_back(chr_row(8'hFF, 1'b0));
    directed.push_back(chr_row(8'hFF, 1'b0));
    directed.push_back(chr_row(8'hFF, 1'b0));
    directed.push_back(chr_row(8'h80, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      cur_row = directed[i];
      if (cur_row.kind == ROW_CFG) write_reg(cur_row.idx, cur_row.val);
      else send_char(cur_row.chr, cur_row.lst, cur_row.typed, cur_row.exp_idx);
    end

    // Random keys over three idling phases, two register settings in each.
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: seg_bucket = 31'h7FFF_FFFF;
        1: seg_bucket = BUCKET_W'($urandom_range(2, 1000));
        2: seg_bucket = 31'd0;
        3: seg_bucket = BUCKET_W'($urandom);
        4: seg_bucket = 31'd4096;
        default: seg_bucket = 31'd1;
      endcase
      write_reg(CFG_CASE_FOLD, CFG_DATA_W'(seg % 2));
      write_reg(CFG_BUCKET_COUNT, seg_bucket);
      // With no sender idling, hold off the receiver so the queue fills and input stalls.
      if (seg == 4) hold_requests++;
      sent = 0;
      while (sent < SEG_CHARS) begin
        pick = $urandom_range(99);
        if (pick < 15) key_len = 1;
        else if (pick < 85) key_len = $urandom_range(2, 8);
        else key_len = $urandom_range(9, 24);
        for (int k = 0; k < key_len; k++) begin
          pick = $urandom_range(99);
          if (pick < 20) byte_val = CHAR_W'(8'h41 + $urandom_range(0, 25));
          else if (pick < 40) byte_val = CHAR_W'(8'h61 + $urandom_range(0, 25));
          else if (pick < 48) byte_val = 8'h00;
          else byte_val = CHAR_W'($urandom_range(0, 255));
          send_char(byte_val, k == key_len - 1, 1'b0, '0);
          sent++;
        end
      end
    end

    // Let every expected result arrive, then allow the back end to settle.
    in_valid <= 1'b0;
    while (bucket_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d keys of %0d characters hashed, %0d results compared",
             key_total, char_total, results_seen);
    $display("tb: %0d register writes, three idling phases and one long output hold",
             settings_total);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* string_bucket_hash.f */
design/sbh_pkg.sv
design/sbh_front.sv
design/sbh_queue.sv
design/sbh_back.sv
design/string_bucket_hash.sv
verif/string_bucket_hash_tb.sv
